// ----- rtl/smmu_pkg.sv -----
// Shared types, command codes and helpers for the segment MMU with LFU TLB.
package smmu_pkg;

  localparam int ADDR_W     = 32;
  localparam int CMD_W      = 3;
  localparam int COUNT_W    = 16;
  localparam int SEGNUM_W   = 3;
  localparam int SLOT_OUT_W = 3;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SEGNUM_W-1:0] segnum_t;

  // Command codes
  localparam cmd_t CMD_LOOKUP    = 3'd0;
  localparam cmd_t CMD_INSERT    = 3'd1;
  localparam cmd_t CMD_TRANSLATE = 3'd2;
  localparam cmd_t CMD_FLUSH     = 3'd3;
  localparam cmd_t CMD_SEG_WRITE = 3'd4;

  localparam count_t COUNT_MAX  = 16'hFFFF;
  localparam count_t COUNT_FREE = 16'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input transfer
    logic commit;  // update state and load the result register
  } ctl_t;

  // TLB operation strobes
  typedef struct packed {
    logic lookup;
    logic insert;
    logic flush;
  } tlb_op_t;

  // Saturating increment of a use count
  function automatic count_t count_inc(input count_t c);
    count_t r;
    r = (c == COUNT_MAX) ? c : count_t'(c + 16'd1);
    return r;
  endfunction

endpackage

// ----- rtl/smmu_ctrl.sv -----
// Controller: two-state sequencer and handshake control.
module smmu_ctrl import smmu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output ctl_t ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  assign in_ready   = (state == ST_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign ctl.load   = in_valid && in_ready;
  assign ctl.commit = (state == ST_EXEC) && out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.load) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/smmu_tlb.sv -----
// Fully associative TLB: tag match, use counts and LFU victim tree.
module smmu_tlb import smmu_pkg::*; #(
  parameter int ENTRIES = 8,
  parameter int SLOT_W  = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  tlb_op_t           op,
  input  addr_t             va,
  input  addr_t             pa,
  output logic              hit,
  output logic [SLOT_W-1:0] hit_slot,
  output addr_t             hit_frame,
  output logic [SLOT_W-1:0] victim_slot
);

  localparam int LEVELS = $clog2(ENTRIES);
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;

  addr_t  tag   [ENTRIES];
  addr_t  frame [ENTRIES];
  count_t cnt   [ENTRIES];

  logic [COUNT_W:0]  node_cnt [NODES];
  logic [SLOT_W-1:0] node_idx [NODES];

  logic   victim_free;
  count_t victim_cnt;
  count_t hit_cnt;

  // Parallel tag compare, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tag[i] == va) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign hit_frame = frame[hit_slot];
  assign hit_cnt   = cnt[hit_slot];

  // Minimum tree over the counts; left child wins ties so the lowest index is kept.
  // Padding leaves carry a count above any real one.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < ENTRIES) begin
        node_cnt[LEAVES-1+i] = {1'b0, cnt[i]};
        node_idx[LEAVES-1+i] = SLOT_W'(i);
      end else begin
        node_cnt[LEAVES-1+i] = '1;
        node_idx[LEAVES-1+i] = '0;
      end
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (node_cnt[2*n+2] < node_cnt[2*n+1]) begin
        node_cnt[n] = node_cnt[2*n+2];
        node_idx[n] = node_idx[2*n+2];
      end else begin
        node_cnt[n] = node_cnt[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end
    end
  end

  // Registered victim; a free entry is the first one with a zero count
  always_ff @(posedge clk) begin
    victim_slot <= node_idx[0];
    victim_free <= (node_cnt[0] == '0);
    victim_cnt  <= node_cnt[0][COUNT_W-1:0];
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (rst || op.flush) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag[i]   <= '1;
        frame[i] <= '1;
        cnt[i]   <= '0;
      end
    end else if (op.lookup && hit) begin
      cnt[hit_slot] <= count_inc(hit_cnt);
    end else if (op.insert) begin
      tag[victim_slot]   <= va;
      frame[victim_slot] <= pa;
      cnt[victim_slot]   <= victim_free ? COUNT_FREE : count_inc(victim_cnt);
    end
  end

endmodule

// ----- rtl/smmu_seg.sv -----
// Segment table memory and bounds-checked translation.
module smmu_seg import smmu_pkg::*; #(
  parameter int IDX_W = 3,
  parameter int OFF_W = 29
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  addr_t            wr_base,
  input  addr_t            wr_limit,
  input  logic [OFF_W-1:0] offset,
  output logic             fault,
  output addr_t            phys
);

  localparam int DEPTH = 1 << IDX_W;

  addr_t base_mem [DEPTH];
  addr_t lim_mem  [DEPTH];

  logic [DEPTH-1:0] valid;
  addr_t            rd_base;
  addr_t            rd_lim;
  logic             rd_ok;
  addr_t            base;
  addr_t            lim;
  logic [ADDR_W:0]  sum;

  // Per-entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      base_mem[wr_idx] <= wr_base;
      lim_mem[wr_idx]  <= wr_limit;
    end
    if (rd_en) begin
      rd_base <= base_mem[rd_idx];
      rd_lim  <= lim_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (rd_en) begin
      rd_ok <= valid[rd_idx];
    end
  end

  // Base plus offset with wrap and limit checks
  assign base  = rd_ok ? rd_base : '0;
  assign lim   = rd_ok ? rd_lim  : '0;
  assign sum   = {1'b0, base} + (ADDR_W+1)'(offset);
  assign fault = (lim == '0) || sum[ADDR_W] || (sum[ADDR_W-1:0] > lim);
  assign phys  = sum[ADDR_W-1:0];

endmodule

// ----- rtl/smmu_dp.sv -----
// Datapath: input capture, TLB and segment units, result selection and register.
module smmu_dp import smmu_pkg::*; #(
  parameter int TLB_ENTRIES = 8,
  parameter int SLOT_W      = 3,
  parameter int SEG_W       = 3,
  parameter int OFF_W       = 29
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  cmd_t                  command,
  input  addr_t                 virtual_address,
  input  addr_t                 physical_address,
  input  segnum_t               segment_number,
  input  addr_t                 segment_base_in,
  input  addr_t                 segment_length_in,
  output logic                  status,
  output addr_t                 result_address,
  output logic [SLOT_OUT_W-1:0] chosen_slot
);

  cmd_t    cmd_q;
  addr_t   va_q;
  addr_t   pa_q;
  segnum_t segn_q;
  addr_t   base_q;
  addr_t   len_q;

  tlb_op_t           tlb_op;
  logic              tlb_hit;
  logic [SLOT_W-1:0] tlb_hit_slot;
  addr_t             tlb_hit_frame;
  logic [SLOT_W-1:0] tlb_victim;

  addr_t            va_hi;
  logic [31:0]      segn_w;
  logic [SEG_W-1:0] seg_rd_idx;
  logic [SEG_W-1:0] seg_wr_idx;
  logic             seg_wr_en;
  logic             seg_fault;
  addr_t            seg_phys;

  logic              res_status;
  addr_t             res_addr;
  logic [SLOT_W-1:0] res_slot;
  logic [31:0]       slot_w;

  // Capture of the accepted transfer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      va_q   <= virtual_address;
      pa_q   <= physical_address;
      segn_q <= segment_number;
      base_q <= segment_base_in;
      len_q  <= segment_length_in;
    end
  end

  // Segment index from the top address bits, read as the transfer is taken
  assign va_hi      = virtual_address >> OFF_W;
  assign seg_rd_idx = va_hi[SEG_W-1:0];
  assign segn_w     = 32'(segn_q);
  assign seg_wr_idx = segn_w[SEG_W-1:0];
  assign seg_wr_en  = ctl.commit && (cmd_q == CMD_SEG_WRITE);

  assign tlb_op.lookup = ctl.commit && (cmd_q == CMD_LOOKUP);
  assign tlb_op.insert = ctl.commit && (cmd_q == CMD_INSERT);
  assign tlb_op.flush  = ctl.commit && (cmd_q == CMD_FLUSH);

  smmu_tlb #(
    .ENTRIES (TLB_ENTRIES),
    .SLOT_W  (SLOT_W)
  ) u_tlb (
    .clk         (clk),
    .rst         (rst),
    .op          (tlb_op),
    .va          (va_q),
    .pa          (pa_q),
    .hit         (tlb_hit),
    .hit_slot    (tlb_hit_slot),
    .hit_frame   (tlb_hit_frame),
    .victim_slot (tlb_victim)
  );

  smmu_seg #(
    .IDX_W (SEG_W),
    .OFF_W (OFF_W)
  ) u_seg (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (ctl.load),
    .rd_idx   (seg_rd_idx),
    .wr_en    (seg_wr_en),
    .wr_idx   (seg_wr_idx),
    .wr_base  (base_q),
    .wr_limit (len_q),
    .offset   (va_q[OFF_W-1:0]),
    .fault    (seg_fault),
    .phys     (seg_phys)
  );

  // Result selection by command
  always_comb begin
    res_status = 1'b0;
    res_addr   = '0;
    res_slot   = '0;
    case (cmd_q)
      CMD_LOOKUP: begin
        res_status = !tlb_hit;
        res_addr   = tlb_hit ? tlb_hit_frame : '0;
        res_slot   = tlb_hit ? tlb_hit_slot : '0;
      end
      CMD_INSERT: begin
        res_slot = tlb_victim;
      end
      CMD_TRANSLATE: begin
        res_status = seg_fault;
        res_addr   = seg_fault ? '0 : seg_phys;
      end
      CMD_FLUSH, CMD_SEG_WRITE: begin
        res_status = 1'b0;
      end
      default: begin
        res_status = 1'b1;
      end
    endcase
  end

  // Slot reported modulo eight
  assign slot_w = 32'(res_slot);

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status         <= res_status;
      result_address <= res_addr;
      chosen_slot    <= slot_w[SLOT_OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/segment_mmu_with_lfu_tlb.sv -----
// Result and out_valid are registered in the execute step that follows the input capture,
// held back while a waiting result still occupies the output.
// One item is in work at a time: the single execute step updates the TLB use counts,
// and the LFU victim register is refreshed from the counts between items.
// A new item is taken while the previous result still waits on the output.
// Reset (synchronous, rst high): TLB tags and frames all ones, counts zero, segment
// valid bits cleared, output empty.
module segment_mmu_with_lfu_tlb import smmu_pkg::*; #(
  parameter int TLB_ENTRIES        = 8,
  parameter int SEGMENT_INDEX_BITS = 3,
  parameter int OFFSET_WIDTH       = 29
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmd_t                  command,
  input  addr_t                 virtual_address,
  input  addr_t                 physical_address,
  input  segnum_t               segment_number,
  input  addr_t                 segment_base_in,
  input  addr_t                 segment_length_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  status,
  output addr_t                 result_address,
  output logic [SLOT_OUT_W-1:0] chosen_slot
);

  localparam int SLOT_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  ctl_t ctl;

  smmu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  smmu_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .SLOT_W      (SLOT_W),
    .SEG_W       (SEGMENT_INDEX_BITS),
    .OFF_W       (OFFSET_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .command           (command),
    .virtual_address   (virtual_address),
    .physical_address  (physical_address),
    .segment_number    (segment_number),
    .segment_base_in   (segment_base_in),
    .segment_length_in (segment_length_in),
    .status            (status),
    .result_address    (result_address),
    .chosen_slot       (chosen_slot)
  );

endmodule

// ----- rtl/smmu_chk.sv -----
// Port-level checker for the segment MMU, bound to the top level.
module smmu_chk import smmu_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  status,
  input addr_t                 result_address,
  input logic [SLOT_OUT_W-1:0] chosen_slot
);

  // Output empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // One item in work at a time: no transfer in the cycle after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // A miss or fault always reports a zero address
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (result_address == '0))
    else $error("nonzero address with miss or fault");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)
      && $stable(result_address) && $stable(chosen_slot)))
    else $error("stalled result changed");

endmodule

bind segment_mmu_with_lfu_tlb smmu_chk u_smmu_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .result_address (result_address),
  .chosen_slot    (chosen_slot)
);
